/* rtl/core/sslf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sslf_pkg;

   localparam int unsigned DEF_SET_DEPTH = 64;
   localparam int unsigned KEY_W         = 32;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned SET_COUNT_W   = 7;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DUP  = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_ZERO = 2'd3
   } status_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_LINE   = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAVE,
      ST_HOLD
   } state_type;

   // token moving along the cell row
   typedef struct packed {
      logic             valid;
      logic             wr_en;
      logic             hit;
      logic             placed;
      logic [KEY_W-1:0] key;
   } token_type;

   typedef struct packed {
      logic                   keep_line;
      logic [KEY_W-1:0]       line_index;
      status_type             status;
      logic [SET_COUNT_W-1:0] set_count;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/sslf_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sslf_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] line_number;

   modport source (output valid, output cmd, output line_number, input ready);
   modport sink (input valid, input cmd, input line_number, output ready);
endinterface

interface sslf_rsp_if;
   logic        valid;
   logic        ready;
   logic        keep_line;
   logic [31:0] line_index;
   logic [1:0]  status;
   logic [6:0]  set_count;

   modport source (output valid, output keep_line, output line_index, output status,
                   output set_count, input ready);
   modport sink (input valid, input keep_line, input line_index, input status,
                 input set_count, output ready);
endinterface

interface sslf_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/sslf_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module sslf_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CNT_W = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [CNT_W-1:0]    count,
   input  wire sslf_pkg::token_type tok_in,
   output sslf_pkg::token_type      tok_out
);
   import sslf_pkg::*;

   logic [KEY_W-1:0] entry_ff;
   logic [KEY_W-1:0] entry_in;
   token_type        tok_ff;
   token_type        tok_in_nx;
   logic             occupied;

   assign occupied = count > CNT_W'(INDEX);

   always_comb begin
      entry_in  = entry_ff;
      tok_in_nx = tok_in;
      if (tok_in.valid && !tok_in.placed && !tok_in.hit) begin
         if (occupied) begin
            if (tok_in.key == entry_ff) begin
               tok_in_nx.hit = 1'b1;
            end else if (tok_in.wr_en && (tok_in.key < entry_ff)) begin
               // swap: keep the smaller key, carry the old entry onward
               entry_in      = tok_in.key;
               tok_in_nx.key = entry_ff;
            end
         end else if (tok_in.wr_en) begin
            entry_in         = tok_in.key;
            tok_in_nx.placed = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_nx;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

/* rtl/core/sorted_set_line_filter_top.sv */
// Sorted set of nonzero line numbers with a line filter. Each request beat is either an
// insert (cmd 0) or one text line (cmd 1); each gives exactly one response beat. The set
// lives in a row of SET_DEPTH cells; a token carrying the beat's key walks the row one cell
// per cycle, comparing, swapping to keep the order, or placing the key in the first free
// cell. The response register is loaded when the token leaves the last cell, or later from
// a hold register while the previous response still waits on rsp_ready. The next request beat
// is taken once that response has been loaded, even while it still waits on rsp_ready.
// No clearing pass follows reset: cells beyond the fill count are never compared.
// The user must write delete_mode over the csr channel only while idle; no logic enforces it.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_line_filter_top #(
   parameter int unsigned SET_DEPTH = sslf_pkg::DEF_SET_DEPTH
) (
   input wire logic   clock,
   input wire logic   reset,
   sslf_req_if.sink   req_bus,
   sslf_rsp_if.source rsp_bus,
   sslf_csr_if.sink   csr_bus
);
   import sslf_pkg::*;

   localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [KEY_W-1:0] counter_ff, counter_in;
   logic             delete_mode_ff;
   token_type        head_ff, head_in;
   logic             item_line_ff, item_zero_ff;
   logic [KEY_W-1:0] item_index_ff;
   result_type       fin_ff, fin_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       res_now;
   logic [CNT_W-1:0] count_next;
   logic [CNT_W+SET_COUNT_W-1:0] count_wide;
   logic             req_take;

   token_type            tok_chain [SET_DEPTH+1];
   logic [SET_DEPTH-1:0] tok_vld;

   assign tok_chain[0] = head_ff;

   for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
      sslf_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .count   (count_ff),
         .tok_in  (tok_chain[i]),
         .tok_out (tok_chain[i+1])
      );
      assign tok_vld[i] = tok_chain[i+1].valid;
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // request beat enters the row
   always_comb begin
      head_in        = head_ff;
      head_in.valid  = req_take;
      head_in.hit    = 1'b0;
      head_in.placed = 1'b0;
      head_in.key    = (req_bus.cmd == CMD_LINE) ? counter_ff : req_bus.line_number;
      head_in.wr_en  = (req_bus.cmd == CMD_INSERT) && (req_bus.line_number != '0)
                       && (count_ff != CNT_W'(SET_DEPTH));
   end

   // result from the token leaving the last cell
   always_comb begin
      count_next = count_ff + CNT_W'(tok_chain[SET_DEPTH].placed);
      count_wide = {{SET_COUNT_W{1'b0}}, count_next};
      res_now.set_count = count_wide[SET_COUNT_W-1:0];
      if (item_line_ff) begin
         res_now.keep_line  = delete_mode_ff ? !tok_chain[SET_DEPTH].hit
                                             : tok_chain[SET_DEPTH].hit;
         res_now.line_index = item_index_ff;
         res_now.status     = STATUS_OK;
      end else begin
         res_now.keep_line  = 1'b0;
         res_now.line_index = '0;
         if (item_zero_ff) begin
            res_now.status = STATUS_ZERO;
         end else if (tok_chain[SET_DEPTH].hit) begin
            res_now.status = STATUS_DUP;
         end else if (tok_chain[SET_DEPTH].placed) begin
            res_now.status = STATUS_OK;
         end else begin
            res_now.status = STATUS_FULL;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      counter_in   = counter_ff;
      fin_in       = fin_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_WAVE;
            end
         end
         ST_WAVE: begin
            if (tok_chain[SET_DEPTH].valid) begin
               count_in = count_next;
               if (item_line_ff && (counter_ff != '1)) begin
                  counter_in = counter_ff + KEY_W'(1);
               end
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_in       = res_now;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  fin_in   = res_now;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_in       = fin_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         counter_ff     <= KEY_W'(1);
         delete_mode_ff <= 1'b1;
         head_ff.valid  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         counter_ff   <= counter_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            delete_mode_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
      rsp_ff <= rsp_in;
      if (req_take) begin
         item_line_ff  <= (req_bus.cmd == CMD_LINE);
         item_zero_ff  <= (req_bus.line_number == '0);
         item_index_ff <= counter_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.keep_line  = rsp_ff.keep_line;
   assign rsp_bus.line_index = rsp_ff.line_index;
   assign rsp_bus.status     = rsp_ff.status;
   assign rsp_bus.set_count  = rsp_ff.set_count;

   // at most one token in the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones({tok_vld, head_ff.valid}) <= 1)
      else $error("more than one token in the cell row");

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(tok_vld[SET_DEPTH-1] || head_ff.valid))
      else $error("token in flight while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SET_DEPTH))
      else $error("fill count beyond depth");

   a_take_starts_wave: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (head_ff.valid && (state_ff == ST_WAVE)))
      else $error("accepted beat did not enter the row");

   a_counter_nonzero: assert property (@(posedge clock) disable iff (reset)
      counter_ff != '0)
      else $error("line counter reached zero");

endmodule

`default_nettype wire
